FILE: sv/grasp_pose_from_box_defines.svh
// Assertion helpers shared by the grasp pose block.
`ifndef GRASP_POSE_FROM_BOX_DEFINES_SVH
`define GRASP_POSE_FROM_BOX_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GPFB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GPFB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/gpfb_pkg.sv
package gpfb_pkg;

  // Port and field widths fixed by the interface.
  localparam int FIELD_W = 48;
  localparam int EXT_W   = 16;
  localparam int NRM_W   = 16;

  // Normalizer internals: magnitudes are scaled so the largest lies in [2^29, 2^30).
  localparam int MAG_W      = 30;
  localparam int SUM_W      = 62;
  localparam int ROOT_W     = 31;
  localparam int SQRT_STEPS = 31;

  // Grasp point sits 20 mm below the top face: offset is (height - 40) / 2.
  localparam logic [EXT_W:0] GRIP_DROP_MM2 = 17'd40;

  // Reset value of the table normal.
  localparam logic signed [NRM_W-1:0] NORMAL_X_RST = 16'sd0;
  localparam logic signed [NRM_W-1:0] NORMAL_Y_RST = 16'sd0;
  localparam logic signed [NRM_W-1:0] NORMAL_Z_RST = 16'sd16384;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_NORMAL_X = 2'd0,
    REG_NORMAL_Y = 2'd1,
    REG_NORMAL_Z = 2'd2
  } cfg_reg_t;

endpackage

FILE: sv/gpfb_norm.sv
module gpfb_norm #(
  parameter int CB = 16,
  parameter int W  = 33,
  parameter int SW = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [W-1:0]  in_vec [3],
  input  logic [SW-1:0]        in_side,
  output logic                 out_valid,
  output logic signed [CB-1:0] out_vec [3],
  output logic                 out_ok,
  output logic [SW-1:0]        out_side
);
  import gpfb_pkg::*;

  localparam int F   = CB - 2;
  localparam int SQ  = SQRT_STEPS;
  localparam int DS  = F + 1;
  localparam int QW  = F + 1;
  localparam int DVW = MAG_W + F + 1;
  localparam int D0  = 5 + SQ;
  localparam int FS  = D0 + DS + 1;
  localparam int NST = FS + 1;
  localparam int PW  = $clog2(W);

  logic              vld_r  [NST];
  logic [SW-1:0]     side_r [NST];
  logic              zero_r [FS];
  logic [2:0]        sgn_r  [FS];

  logic [W-1:0]      mag0_r [3];
  logic [W-1:0]      max0_r;
  logic [W-1:0]      mag1_r [3];
  logic [PW-1:0]     pos1_r;
  logic [MAG_W-1:0]  mg_r   [2:D0-1][3];
  logic [2*MAG_W-1:0] sq3_r [3];
  logic [SUM_W-1:0]  sum4_r;
  logic [SUM_W-1:0]  sx_r   [SQ-1];
  logic [SUM_W-1:0]  sr_r   [SQ];
  logic [ROOT_W-1:0] nn_r   [DS];
  logic [DVW-1:0]    rem_r  [DS][3];
  logic [QW-1:0]     q_r    [DS+1][3];
  logic signed [CB-1:0] o_r [3];
  logic              ok_r;

  logic [W-1:0]      a0 [3];
  logic [W-1:0]      mx;
  logic [PW-1:0]     pos;
  logic [MAG_W-1:0]  sc [3];

  // Valid bits and side payload ride along with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NST; s++) vld_r[s] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int s = 1; s < NST; s++) vld_r[s] <= vld_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= in_side;
      for (int s = 1; s < NST; s++) side_r[s] <= side_r[s-1];
    end
  end

  // Stage 0: magnitudes, signs and the largest magnitude.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a0[i] = in_vec[i][W-1] ? W'(-in_vec[i]) : W'(in_vec[i]);
    end
    mx = a0[0];
    if (a0[1] > mx) mx = a0[1];
    if (a0[2] > mx) mx = a0[2];
  end

  // The zero and sign flags then travel down to the final stage.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        mag0_r[i]   <= a0[i];
        sgn_r[0][i] <= in_vec[i][W-1];
      end
      max0_r    <= mx;
      zero_r[0] <= (mx == '0);
      for (int s = 1; s < FS; s++) begin
        zero_r[s] <= zero_r[s-1];
        sgn_r[s]  <= sgn_r[s-1];
      end
    end
  end

  // Stage 1: position of the leading one of the largest magnitude.
  always_comb begin
    pos = '0;
    for (int b = 0; b < W; b++) begin
      if (max0_r[b]) pos = PW'(b);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pos1_r <= pos;
      for (int i = 0; i < 3; i++) mag1_r[i] <= mag0_r[i];
    end
  end

  // Stage 2: shift so the leading one lands on bit 29; shifting down truncates.
  always_comb begin
    logic [W+MAG_W-1:0] wide;
    int sh;
    for (int i = 0; i < 3; i++) begin
      wide = {{MAG_W{1'b0}}, mag1_r[i]};
      sh   = int'(pos1_r) - (MAG_W - 1);
      if (sh >= 0) wide = wide >> sh;
      else         wide = wide << (-sh);
      sc[i] = wide[MAG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) mg_r[2][i] <= sc[i];
      for (int s = 3; s < D0; s++) begin
        for (int i = 0; i < 3; i++) mg_r[s][i] <= mg_r[s-1][i];
      end
    end
  end

  // Stages 3 and 4: squares, then their sum.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) sq3_r[i] <= mg_r[2][i] * mg_r[2][i];
      sum4_r <= SUM_W'(sq3_r[0]) + SUM_W'(sq3_r[1]) + SUM_W'(sq3_r[2]);
    end
  end

  // Square root, one result bit per stage.
  for (genvar k = 0; k < SQ; k++) begin : g_sqrt
    localparam logic [SUM_W-1:0] BITV = SUM_W'(1) << (2 * (SQ - 1 - k));
    logic [SUM_W-1:0] xi;
    logic [SUM_W-1:0] ri;
    logic [SUM_W-1:0] t;

    if (k == 0) begin : g_first
      assign xi = sum4_r;
      assign ri = '0;
    end else begin : g_next
      assign xi = sx_r[k-1];
      assign ri = sr_r[k-1];
    end
    assign t = ri + BITV;

    always_ff @(posedge clk) begin
      if (en) begin
        sr_r[k] <= (xi >= t) ? (ri >> 1) + BITV : (ri >> 1);
      end
    end

    if (k < SQ - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          sx_r[k] <= (xi >= t) ? xi - t : xi;
        end
      end
    end
  end

  // Division setup: rounded dividend is mag * 2^F + n / 2.
  always_ff @(posedge clk) begin
    if (en) begin
      nn_r[0] <= sr_r[SQ-1][ROOT_W-1:0];
      for (int i = 0; i < 3; i++) begin
        rem_r[0][i] <= (DVW'(mg_r[D0-1][i]) << F) + DVW'(sr_r[SQ-1][ROOT_W-1:1]);
        q_r[0][i]   <= '0;
      end
    end
  end

  // Restoring division, one quotient bit per stage, three lanes.
  for (genvar j = 1; j <= DS; j++) begin : g_div
    localparam int B = DS - j;
    logic [DVW-1:0] dv;
    logic           ge [3];

    assign dv = DVW'(nn_r[j-1]) << B;
    always_comb begin
      for (int i = 0; i < 3; i++) ge[i] = (rem_r[j-1][i] >= dv);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          q_r[j][i] <= ge[i] ? (q_r[j-1][i] | (QW'(1) << B)) : q_r[j-1][i];
        end
      end
    end

    if (j < DS) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          nn_r[j] <= nn_r[j-1];
          for (int i = 0; i < 3; i++) begin
            rem_r[j][i] <= ge[i] ? rem_r[j-1][i] - dv : rem_r[j-1][i];
          end
        end
      end
    end
  end

  // Final stage: restore the signs; a zero vector gives zero and a cleared flag.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (zero_r[FS-1])      o_r[i] <= '0;
        else if (sgn_r[FS-1][i]) o_r[i] <= -CB'(q_r[DS][i]);
        else                   o_r[i] <= CB'(q_r[DS][i]);
      end
      ok_r <= !zero_r[FS-1];
    end
  end

  assign out_valid = vld_r[NST-1];
  assign out_side  = side_r[NST-1];
  assign out_vec   = o_r;
  assign out_ok    = ok_r;

endmodule

FILE: sv/grasp_pose_from_box.sv
// Flow: stages A to E, long-axis normalizer, stages F and G, jaw-axis normalizer, output register.
// Throughput: one transaction per cycle unless the output stalls; every stage is registered and advances together.
// Each of the two normalizers spends 31 stages on the square root and one stage per quotient bit.
// A stalled result holds the whole pipeline; nothing is dropped or repeated.
// Reset (rst_n low, synchronous) empties the pipeline and restores the table normal to +z.
`include "grasp_pose_from_box_defines.svh"
module grasp_pose_from_box #(
  parameter int COMPONENT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [47:0] in_axis_first,
  input  logic [47:0] in_axis_second,
  input  logic [47:0] in_axis_third,
  input  logic [15:0] in_extent_height,
  input  logic [15:0] in_extent_width,
  input  logic [15:0] in_extent_length,
  input  logic [47:0] in_center_point,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [47:0] out_grip_position,
  output logic [47:0] out_jaw_axis,
  output logic [47:0] out_long_axis,
  output logic [47:0] out_approach_axis,
  output logic [15:0] out_grip_width,
  output logic [15:0] out_grip_length,
  output logic        out_degenerate,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);
  import gpfb_pkg::*;

  localparam int CB  = COMPONENT_BITS;
  localparam int F   = CB - 2;
  localparam int PW  = 3 * CB;
  localparam int PMW = CB + NRM_W;
  localparam int DW  = PMW + 2;
  localparam int XW  = 2 * CB;
  localparam int CW  = XW + 1;
  localparam int QW  = PMW - F - 1;
  localparam int PSW = CB + 18;
  localparam int SW1 = 6 * CB + 2 * EXT_W;
  localparam int SW2 = 3 * CB + SW1 + 1;
  localparam logic signed [CB-1:0] CMIN = {1'b1, {(CB-1){1'b0}}};
  localparam logic signed [CB-1:0] CMAX = ~CMIN;

  function automatic logic signed [CB-1:0] comp_of(input logic [FIELD_W-1:0] w, input int i);
    logic [PW+FIELD_W-1:0] ext_w;
    ext_w = {{PW{1'b0}}, w};
    return ext_w[i*CB +: CB];
  endfunction

  function automatic logic [FIELD_W-1:0] pack3(input logic signed [CB-1:0] v [3]);
    logic [PW+FIELD_W-1:0] t;
    t = {{FIELD_W{1'b0}}, v[2], v[1], v[0]};
    return t[FIELD_W-1:0];
  endfunction

  function automatic logic signed [CB-1:0] neg_sat(input logic signed [CB-1:0] v);
    if (v == CMIN) return CMAX;
    return -v;
  endfunction

  function automatic logic signed [CB-1:0] sat_cb(input logic signed [PSW-1:0] s);
    if (s[PSW-1:CB-1] == '0 || s[PSW-1:CB-1] == '1) return s[CB-1:0];
    return s[PSW-1] ? CMIN : CMAX;
  endfunction

  logic en;
  logic va_r, vb_r, vc_r, vd_r, ve_r, vf_r, vg_r, out_valid_r;

  // The whole pipeline advances whenever the output register can take a result.
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // Table normal registers.
  logic signed [NRM_W-1:0] nrm_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nrm_r[0] <= NORMAL_X_RST;
      nrm_r[1] <= NORMAL_Y_RST;
      nrm_r[2] <= NORMAL_Z_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NORMAL_X: nrm_r[0] <= cfg_wdata;
        REG_NORMAL_Y: nrm_r[1] <= cfg_wdata;
        REG_NORMAL_Z: nrm_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Valid bits for the stages outside the normalizers.
  logic n1_valid, n2_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
      ve_r <= 1'b0;
      vf_r <= 1'b0;
      vg_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vc_r;
      ve_r <= vd_r;
      vf_r <= n1_valid;
      vg_r <= vf_r;
      out_valid_r <= n2_valid;
    end
  end

  // Stage A: unpack the transaction and multiply each axis by the normal.
  logic signed [CB-1:0]  ax_in   [3][3];
  logic signed [CB-1:0]  ctr_in  [3];
  logic signed [CB-1:0]  ax_a_r  [3][3];
  logic signed [PMW-1:0] prod_a_r [3][3];
  logic [EXT_W-1:0]      ext_a_r [3];
  logic signed [CB-1:0]  ctr_a_r [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ax_in[0][k] = comp_of(in_axis_first, k);
      ax_in[1][k] = comp_of(in_axis_second, k);
      ax_in[2][k] = comp_of(in_axis_third, k);
      ctr_in[k]   = comp_of(in_center_point, k);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          ax_a_r[i][k]   <= ax_in[i][k];
          prod_a_r[i][k] <= ax_in[i][k] * nrm_r[k];
        end
        ctr_a_r[i] <= ctr_in[i];
      end
      ext_a_r[0] <= in_extent_height;
      ext_a_r[1] <= in_extent_width;
      ext_a_r[2] <= in_extent_length;
    end
  end

  // Stage B: dot products with the normal.
  logic signed [DW-1:0] dot_b_r [3];
  logic signed [CB-1:0] ax_b_r  [3][3];
  logic [EXT_W-1:0]     ext_b_r [3];
  logic signed [CB-1:0] ctr_b_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dot_b_r[i] <= DW'(prod_a_r[i][0]) + DW'(prod_a_r[i][1]) + DW'(prod_a_r[i][2]);
        ax_b_r[i]  <= ax_a_r[i];
        ctr_b_r[i] <= ctr_a_r[i];
        ext_b_r[i] <= ext_a_r[i];
      end
    end
  end

  // Stage C: pick and orient the approach axis, then the jaw axis.
  logic [DW-1:0]        dmag [3];
  logic [1:0]           idx, ia, ib, shorter, longer;
  logic signed [CB-1:0] z_sel [3];
  logic signed [EXT_W:0] hm;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dmag[i] = dot_b_r[i][DW-1] ? DW'(-dot_b_r[i]) : DW'(dot_b_r[i]);
    end
    idx = 2'd0;
    if (dmag[1] > dmag[idx]) idx = 2'd1;
    if (dmag[2] > dmag[idx]) idx = 2'd2;
    for (int k = 0; k < 3; k++) begin
      z_sel[k] = dot_b_r[idx][DW-1] ? neg_sat(ax_b_r[idx][k]) : ax_b_r[idx][k];
    end
    ia = (idx == 2'd0) ? 2'd1 : 2'd0;
    ib = (idx == 2'd2) ? 2'd1 : 2'd2;
    shorter = (ext_b_r[ia] <= ext_b_r[ib]) ? ia : ib;
    longer  = (ext_b_r[ia] <= ext_b_r[ib]) ? ib : ia;
    hm = $signed({1'b0, ext_b_r[idx]}) - $signed(GRIP_DROP_MM2);
  end

  logic signed [CB-1:0] z_c_r   [3];
  logic signed [CB-1:0] jaw_c_r [3];
  logic signed [CB-1:0] ctr_c_r [3];
  logic [EXT_W-1:0]     wid_c_r, len_c_r, hmag_c_r;
  logic                 hneg_c_r;

  always_ff @(posedge clk) begin
    if (en) begin
      z_c_r    <= z_sel;
      jaw_c_r  <= ax_b_r[shorter];
      ctr_c_r  <= ctr_b_r;
      wid_c_r  <= ext_b_r[shorter];
      len_c_r  <= ext_b_r[longer];
      hmag_c_r <= hm[EXT_W] ? EXT_W'(-hm) : EXT_W'(hm);
      hneg_c_r <= hm[EXT_W];
    end
  end

  // Stage D: products of the first cross product and of the grasp offset.
  logic signed [XW-1:0]  m_d_r [6];
  logic [PMW-1:0]        p_d_r [3];
  logic signed [CB-1:0]  z_d_r [3];
  logic signed [CB-1:0]  ctr_d_r [3];
  logic [EXT_W-1:0]      wid_d_r, len_d_r;
  logic                  hneg_d_r;

  always_ff @(posedge clk) begin
    if (en) begin
      m_d_r[0] <= z_c_r[1] * jaw_c_r[2];
      m_d_r[1] <= z_c_r[2] * jaw_c_r[1];
      m_d_r[2] <= z_c_r[2] * jaw_c_r[0];
      m_d_r[3] <= z_c_r[0] * jaw_c_r[2];
      m_d_r[4] <= z_c_r[0] * jaw_c_r[1];
      m_d_r[5] <= z_c_r[1] * jaw_c_r[0];
      for (int k = 0; k < 3; k++) begin
        p_d_r[k] <= PMW'($unsigned(z_c_r[k][CB-1] ? CB'(-z_c_r[k]) : CB'(z_c_r[k])))
                    * PMW'(hmag_c_r);
      end
      z_d_r    <= z_c_r;
      ctr_d_r  <= ctr_c_r;
      wid_d_r  <= wid_c_r;
      len_d_r  <= len_c_r;
      hneg_d_r <= hneg_c_r;
    end
  end

  // Stage E: cross product differences and the saturated grasp point.
  logic signed [CB-1:0]  pos_e [3];
  logic signed [CW-1:0]  c_e_r [3];
  logic [SW1-1:0]        s1_e_r;

  always_comb begin
    logic [PMW-1:0]        pr;
    logic [QW-1:0]         qv;
    logic signed [PSW-1:0] s;
    for (int k = 0; k < 3; k++) begin
      pr = p_d_r[k] + (PMW'(1) << F);
      qv = pr[PMW-1:F+1];
      if (z_d_r[k][CB-1] != hneg_d_r) s = PSW'(ctr_d_r[k]) - $signed(PSW'(qv));
      else                            s = PSW'(ctr_d_r[k]) + $signed(PSW'(qv));
      pos_e[k] = sat_cb(s);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_e_r[0] <= CW'(m_d_r[0]) - CW'(m_d_r[1]);
      c_e_r[1] <= CW'(m_d_r[2]) - CW'(m_d_r[3]);
      c_e_r[2] <= CW'(m_d_r[4]) - CW'(m_d_r[5]);
      s1_e_r <= {len_d_r, wid_d_r, pos_e[2], pos_e[1], pos_e[0],
                 z_d_r[2], z_d_r[1], z_d_r[0]};
    end
  end

  // Long axis: normalized approach x jaw.
  logic signed [CB-1:0] y_n [3];
  logic                 ok1_n;
  logic [SW1-1:0]       s1_n;

  gpfb_norm #(.CB(CB), .W(CW), .SW(SW1)) u_norm_long (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (ve_r),
    .in_vec    (c_e_r),
    .in_side   (s1_e_r),
    .out_valid (n1_valid),
    .out_vec   (y_n),
    .out_ok    (ok1_n),
    .out_side  (s1_n)
  );

  // Stages F and G: second cross product, long x approach.
  logic signed [CB-1:0] zf [3];

  always_comb begin
    for (int k = 0; k < 3; k++) zf[k] = s1_n[k*CB +: CB];
  end

  logic signed [XW-1:0] m_f_r [6];
  logic signed [CB-1:0] y_f_r [3];
  logic                 ok1_f_r;
  logic [SW1-1:0]       s1_f_r;

  always_ff @(posedge clk) begin
    if (en) begin
      m_f_r[0] <= y_n[1] * zf[2];
      m_f_r[1] <= y_n[2] * zf[1];
      m_f_r[2] <= y_n[2] * zf[0];
      m_f_r[3] <= y_n[0] * zf[2];
      m_f_r[4] <= y_n[0] * zf[1];
      m_f_r[5] <= y_n[1] * zf[0];
      y_f_r    <= y_n;
      ok1_f_r  <= ok1_n;
      s1_f_r   <= s1_n;
    end
  end

  logic signed [CW-1:0] c_g_r [3];
  logic [SW2-1:0]       s2_g_r;

  always_ff @(posedge clk) begin
    if (en) begin
      c_g_r[0] <= CW'(m_f_r[0]) - CW'(m_f_r[1]);
      c_g_r[1] <= CW'(m_f_r[2]) - CW'(m_f_r[3]);
      c_g_r[2] <= CW'(m_f_r[4]) - CW'(m_f_r[5]);
      s2_g_r   <= {ok1_f_r, s1_f_r, y_f_r[2], y_f_r[1], y_f_r[0]};
    end
  end

  // Jaw axis: normalized long x approach.
  logic signed [CB-1:0] x_n [3];
  logic                 ok2_n;
  logic [SW2-1:0]       s2_n;

  gpfb_norm #(.CB(CB), .W(CW), .SW(SW2)) u_norm_jaw (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (vg_r),
    .in_vec    (c_g_r),
    .in_side   (s2_g_r),
    .out_valid (n2_valid),
    .out_vec   (x_n),
    .out_ok    (ok2_n),
    .out_side  (s2_n)
  );

  // Output register.
  logic signed [CB-1:0] y_o [3];
  logic signed [CB-1:0] z_o [3];
  logic signed [CB-1:0] p_o [3];
  logic [SW1-1:0]       s1_o;

  always_comb begin
    s1_o = s2_n[3*CB +: SW1];
    for (int k = 0; k < 3; k++) begin
      y_o[k] = s2_n[k*CB +: CB];
      z_o[k] = s1_o[k*CB +: CB];
      p_o[k] = s1_o[3*CB + k*CB +: CB];
    end
  end

  logic [FIELD_W-1:0] pos_r, jaw_r, long_r, appr_r;
  logic [EXT_W-1:0]   wid_r, len_r;
  logic               degen_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pos_r   <= pack3(p_o);
      jaw_r   <= pack3(x_n);
      long_r  <= pack3(y_o);
      appr_r  <= pack3(z_o);
      wid_r   <= s1_o[6*CB +: EXT_W];
      len_r   <= s1_o[6*CB+EXT_W +: EXT_W];
      degen_r <= !(s2_n[SW2-1] && ok2_n);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_grip_position = pos_r;
  assign out_jaw_axis      = jaw_r;
  assign out_long_axis     = long_r;
  assign out_approach_axis = appr_r;
  assign out_grip_width    = wid_r;
  assign out_grip_length   = len_r;
  assign out_degenerate    = degen_r;

  // A degenerate frame always comes with a zero jaw axis.
  `GPFB_ASSERT_NOW(a_degen_jaw, out_valid_r && degen_r, jaw_r == '0, "degenerate frame with nonzero jaw axis")
  // The jaw side is never the longer horizontal side.
  `GPFB_ASSERT_NOW(a_width_order, out_valid_r, wid_r <= len_r, "grip width exceeds grip length")
  // An accepted transaction occupies the first stage on the next cycle.
  `GPFB_ASSERT_NEXT(a_first_stage, in_valid && in_ready, va_r, "accepted transaction lost at entry")

endmodule
